// ===== hw/rtl/lmps_pkg.sv =====
// shared constants, transaction types and write port struct for the led matrix pwm scanner
package lmps_pkg;

  localparam int ROWS    = 5;
  localparam int COLUMNS = 5;
  localparam int PHASES  = 8;

  // field widths of the transactions
  localparam int OPCODE_W    = 1;
  localparam int COORD_W     = 3;
  localparam int BRIGHT_W    = 9;
  localparam int DRIVE_W     = 5;
  localparam int ROW_INDEX_W = 3;
  localparam int PHASE_OUT_W = 3;

  localparam int FULL_SCALE  = 256;
  localparam int ROW_IDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_IDX_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PHASE_W     = $clog2(PHASES);
  // level = brightness * PHASES / FULL_SCALE, a shift since both are powers of two
  localparam int LEVEL_SHIFT = $clog2(FULL_SCALE) - PHASE_W;
  localparam int LEVEL_W     = BRIGHT_W - LEVEL_SHIFT;

  localparam logic [OPCODE_W-1:0] OP_SCAN  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [BRIGHT_W-1:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]     row_drive;
    logic [DRIVE_W-1:0]     column_drive;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [PHASE_OUT_W-1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [BRIGHT_W-1:0] brightness;
  } fb_wr_t;

  typedef logic [COLUMNS-1:0][LEVEL_W-1:0] row_levels_t;

endpackage

// ===== hw/rtl/led_matrix_pwm_scanner_top.sv =====
// top level of the led matrix pwm scanner: input register and transaction steering
// Drives a multiplexed 5x5 LED matrix with 8-phase PWM brightness. A write
// transaction stores level brightness>>5 (brightness 0..256 is 0.0..1.0) for one
// pixel and gives no result; writes with row or column of 5 or more, or with
// brightness above 256, are dropped. A scan transaction returns the one-hot row
// drive and the active-low column drive for the current row, then advances the
// row, stepping the phase after the last row. The framebuffer read and column
// compare run combinationally from the input register into the result register,
// so a new transaction is taken every cycle and a scan result passes through the
// input register and then the result register; only a scan waiting on a held result
// register stalls the input. Framebuffer, row and phase are cleared by reset.
module led_matrix_pwm_scanner_top
  import lmps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic                 in_valid_r;
  in_item_t             in_data_r;
  logic                 is_write;
  logic                 scan_ready;
  logic                 scan_en;
  logic                 exec_fire;
  fb_wr_t               fb_wr;
  logic [ROW_IDX_W-1:0] rd_row;
  row_levels_t          rd_levels;

  assign is_write  = (in_data_r.opcode == OP_WRITE);
  assign exec_fire = in_valid_r && (is_write || scan_ready);
  assign scan_en   = in_valid_r && !is_write && scan_ready;
  assign in_ready  = !in_valid_r || exec_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_comb begin
    fb_wr.en         = in_valid_r && is_write;
    fb_wr.column     = in_data_r.column;
    fb_wr.row        = in_data_r.row;
    fb_wr.brightness = in_data_r.brightness;
  end

  lmps_framebuffer u_framebuffer (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (fb_wr),
    .rd_row    (rd_row),
    .rd_levels (rd_levels)
  );

  lmps_scan_unit u_scan_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_en    (scan_en),
    .scan_ready (scan_ready),
    .rd_row     (rd_row),
    .rd_levels  (rd_levels),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== hw/rtl/lmps_framebuffer.sv =====
// pixel level framebuffer: range-checked write with level conversion, one row read
module lmps_framebuffer
  import lmps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  fb_wr_t               wr,
  input  logic [ROW_IDX_W-1:0] rd_row,
  output row_levels_t          rd_levels
);

  row_levels_t rows_r [ROWS];

  logic               wr_ok;
  logic [LEVEL_W-1:0] wr_level;

  // out of range coordinates and brightness above full scale store nothing
  assign wr_ok = wr.en
              && (32'(wr.column) < COLUMNS)
              && (32'(wr.row) < ROWS)
              && (32'(wr.brightness) <= FULL_SCALE);
  assign wr_level = wr.brightness[BRIGHT_W-1:LEVEL_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        rows_r[r] <= '0;
      end
    end else if (wr_ok) begin
      rows_r[wr.row[ROW_IDX_W-1:0]][wr.column[COL_IDX_W-1:0]] <= wr_level;
    end
  end

  assign rd_levels = rows_r[rd_row];

endmodule

// ===== hw/rtl/lmps_scan_unit.sv =====
// scan row and pwm phase counters, column compare and result register
module lmps_scan_unit
  import lmps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 scan_en,
  output logic                 scan_ready,
  output logic [ROW_IDX_W-1:0] rd_row,
  input  row_levels_t          rd_levels,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  logic [ROW_IDX_W-1:0] row_r, row_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic                 out_valid_r;
  out_item_t            out_data_r, out_data_nxt;
  logic                 last_row;
  logic [ROWS-1:0]      row_onehot;
  logic [COLUMNS-1:0]   col_bits;

  assign scan_ready = !out_valid_r || out_ready;
  assign rd_row     = row_r;
  assign last_row   = (32'(row_r) == ROWS - 1);

  always_comb begin
    row_onehot = ROWS'(1) << row_r;
    // column line low where the pixel is lit in this phase
    for (int c = 0; c < COLUMNS; c++) begin
      col_bits[c] = !(rd_levels[c] > LEVEL_W'(phase_r));
    end
    out_data_nxt.row_drive    = DRIVE_W'(row_onehot);
    out_data_nxt.column_drive = DRIVE_W'(col_bits);
    out_data_nxt.row_index    = ROW_INDEX_W'(row_r);
    out_data_nxt.phase        = PHASE_OUT_W'(phase_r);

    row_nxt   = row_r;
    phase_nxt = phase_r;
    if (scan_en) begin
      if (last_row) begin
        row_nxt   = '0;
        phase_nxt = (32'(phase_r) == PHASES - 1) ? '0 : phase_r + 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      if (scan_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_row_drive_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.row_drive == (DRIVE_W'(1) << out_data_r.row_index)))
    else $error("row drive does not match row index");

  a_phase_holds_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_en && !last_row) |=> $stable(phase_r))
    else $error("phase moved before the last row");

  a_phase_steps_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_en && last_row) |=> (row_r == '0 && phase_r != $past(phase_r)))
    else $error("phase did not advance on row wrap");

  a_no_scan_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    scan_en |-> scan_ready)
    else $error("scan issued while result register is held");
`endif

endmodule

// ===== sim/led_matrix_pwm_scanner_top_tb.sv =====
// testbench for the led matrix pwm scanner: directed, frame sweep and mixed random tests
module led_matrix_pwm_scanner_top_tb;
  import lmps_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int FRAME_COUNT    = 18;
  localparam int MIXED_ITEMS    = 600;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  led_matrix_pwm_scanner_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // own copy of the framebuffer and scan position
  logic [3:0]  fb_level [ROWS*COLUMNS];
  int unsigned scan_pos;
  int unsigned pwm_step;
  out_item_t   drive_expect_q [$];

  int unsigned mismatches;
  int unsigned scans_checked;
  int unsigned writes_stored;
  int unsigned writes_dropped;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_item_t make_item(input logic op, input int unsigned col,
                                         input int unsigned row, input int unsigned bri);
    in_item_t t;
    t.opcode     = op;
    t.column     = COORD_W'(col);
    t.row        = COORD_W'(row);
    t.brightness = BRIGHT_W'(bri);
    return t;
  endfunction

  // update the framebuffer copy, or compute the drive lines of a scan
  task automatic track_transaction(input in_item_t t);
    out_item_t drive;
    if (t.opcode == OP_WRITE) begin
      if (t.column < COLUMNS && t.row < ROWS && t.brightness <= FULL_SCALE) begin
        fb_level[t.row * COLUMNS + t.column] = 4'((t.brightness * PHASES) / FULL_SCALE);
        writes_stored++;
      end else begin
        writes_dropped++;
      end
    end else begin
      drive.row_drive    = DRIVE_W'(1) << scan_pos;
      for (int c = 0; c < COLUMNS; c++)
        drive.column_drive[c] = (fb_level[scan_pos * COLUMNS + c] <= pwm_step);
      drive.row_index    = ROW_INDEX_W'(scan_pos);
      drive.phase        = PHASE_OUT_W'(pwm_step);
      drive_expect_q.push_back(drive);
      if (scan_pos == ROWS - 1) begin
        scan_pos = 0;
        pwm_step = (pwm_step + 1) % PHASES;
      end else begin
        scan_pos++;
      end
    end
  endtask

  // input transactions are tracked before results are checked, both on the same edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        track_transaction(in_data);
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (drive_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: row_drive %b column_drive %b row %0d phase %0d",
                     out_data.row_drive, out_data.column_drive, out_data.row_index,
                     out_data.phase);
        end else begin
          want = drive_expect_q.pop_front();
          scans_checked++;
          if (out_data.row_drive !== want.row_drive ||
              out_data.column_drive !== want.column_drive ||
              out_data.row_index !== want.row_index || out_data.phase !== want.phase) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("scan %0d mismatch: expected rd %b cd %b row %0d ph %0d",
                       scans_checked, want.row_drive, want.column_drive, want.row_index,
                       want.phase);
              $display("  got rd %b cd %b row %0d ph %0d",
                       out_data.row_drive, out_data.column_drive,
                       out_data.row_index, out_data.phase);
            end
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, drive_expect_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver back-pressure: switches between always ready, random, periodic and long stalls
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(32, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((rx_mode_left % 3) == 0);
      default: begin
        if (rx_hold == 0) begin
          out_ready <= ~out_ready;
          rx_hold = $urandom_range(1, 12);
        end else begin
          rx_hold--;
        end
      end
    endcase
  end

  // sender works in bursts; valid stays high across back-to-back transactions
  task automatic send_item(input in_item_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_expect_q.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic int unsigned pick_brightness();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return FULL_SCALE;
      2: return $urandom_range(1, 8) * 32 - 1;  // just below a level step
      3: return $urandom_range(0, 8) * 32;      // exactly on a level step
      default: return $urandom_range(0, FULL_SCALE);
    endcase
  endfunction

  task automatic test_directed_edges();
    send_item(make_item(OP_WRITE, 0, 0, 256));   // full scale, always lit
    send_item(make_item(OP_WRITE, 4, 4, 255));
    send_item(make_item(OP_WRITE, 1, 0, 31));    // rounds down to dark
    send_item(make_item(OP_WRITE, 2, 0, 32));
    send_item(make_item(OP_WRITE, 3, 0, 257));   // above full scale, dropped
    send_item(make_item(OP_WRITE, 4, 0, 511));
    send_item(make_item(OP_WRITE, 5, 0, 100));   // column out of range
    send_item(make_item(OP_WRITE, 0, 5, 100));   // row out of range
    send_item(make_item(OP_WRITE, 7, 7, 256));
    send_item(make_item(OP_WRITE, 6, 2, 0));
    send_item(make_item(OP_WRITE, 0, 4, 224));
    send_item(make_item(OP_WRITE, 3, 3, 128));
    send_item(make_item(OP_SCAN, 7, 7, 511));    // scan ignores the other fields
    repeat (9) send_item(make_item(OP_SCAN, 0, 0, 0));
    send_item(make_item(OP_WRITE, 0, 0, 0));     // clear a lit pixel
    repeat (5) send_item(make_item(OP_SCAN, 0, 0, 0));
  endtask

  // full frame writes followed by a sweep through every row and phase
  task automatic test_frame_sweeps();
    for (int f = 0; f < FRAME_COUNT; f++) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          if ($urandom_range(0, 7) == 0)
            send_item(make_item(OP_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 511)));
          send_item(make_item(OP_WRITE, c, r, pick_brightness()));
        end
      end
      repeat (ROWS * PHASES) send_item(make_item(OP_SCAN, $urandom_range(0, 7),
                                                 $urandom_range(0, 7), $urandom_range(0, 511)));
      if (f == FRAME_COUNT / 2)
        pause_until_drained();
    end
  endtask

  task automatic test_mixed_noise();
    int unsigned pick;
    for (int i = 0; i < MIXED_ITEMS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        send_item(make_item(OP_SCAN, 0, 0, 0));
      else if (pick < 8)
        send_item(make_item(OP_WRITE, $urandom_range(0, COLUMNS - 1),
                            $urandom_range(0, ROWS - 1), pick_brightness()));
      else
        send_item(make_item(($urandom_range(0, 1) != 0) ? OP_WRITE : OP_SCAN,
                            $urandom_range(0, 7), $urandom_range(0, 7),
                            $urandom_range(0, 511)));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    for (int i = 0; i < ROWS * COLUMNS; i++)
      fb_level[i] = '0;
    scan_pos       = 0;
    pwm_step       = 0;
    mismatches     = 0;
    scans_checked  = 0;
    writes_stored  = 0;
    writes_dropped = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    rx_mode        = 0;
    rx_mode_left   = 0;
    rx_hold        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    pause_until_drained();
    test_frame_sweeps();
    pause_until_drained();
    test_mixed_noise();

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (drive_expect_q.size() != 0)
      mismatches += drive_expect_q.size();

    $display("covered %0d pixel writes stored, %0d dropped, %0d scan results checked",
             writes_stored, writes_dropped, scans_checked);
    $display("all rows and pwm phases swept with sender gaps and receiver stalls, %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
